/* hdl/swerve_wheel_speed_angle_top_macros.svh */
// Assertion macros used by the checker file.
`ifndef SWERVE_WHEEL_SPEED_ANGLE_TOP_MACROS_SVH
`define SWERVE_WHEEL_SPEED_ANGLE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWV_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWV_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/swv_pkg.sv */
// Types, constants and the CORDIC arctangent table for the swerve wheel block.
package swv_pkg;

  localparam int NUM_WHEELS_DEFAULT = 4;
  localparam int MAX_WHEELS         = 4;

  localparam int VEL_W   = 16;               // command fields
  localparam int POS_W   = 16;               // one coordinate of a position
  localparam int ARM_W   = POS_W + 1;        // lever arm component
  localparam int TERM_W  = 34;               // Q.24 wheel velocity sum
  localparam int FRAC_DROP = 8;              // Q.24 -> Q.16
  localparam int WV_W    = TERM_W - FRAC_DROP; // Q.16 wheel velocity component
  localparam int PROD_W  = 2 * WV_W;
  localparam int SQ_W    = 50;               // sum of squares, even width
  localparam int ROOT_STEPS   = SQ_W / 2;
  localparam int CORDIC_STEPS = 18;
  localparam int CORDIC_W     = 28;
  localparam int ACC_W        = 32;
  localparam int STEP_W       = 5;
  localparam int SPEED_W      = 16;
  localparam int ANGLE_W      = 16;
  localparam int WIDX_W       = 2;
  localparam int ROUND_HALF   = 128;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int REG_IDX_W    = 3;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] yaw_rate;
  } cmd_t;

  typedef struct packed {
    logic [WIDX_W-1:0]         wheel_index;
    logic [SPEED_W-1:0]        wheel_speed;
    logic signed [ANGLE_W-1:0] wheel_angle;
    logic                      last_wheel;
  } res_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROT_CENTER = 3'd0,
    REG_WHEEL0     = 3'd1,
    REG_WHEEL1     = 3'd2,
    REG_WHEEL2     = 3'd3,
    REG_WHEEL3     = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_RY,
    ST_MUL_RX,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SUM,
    ST_VEC_GO,
    ST_VEC_WAIT,
    ST_ZERO,
    ST_SEND
  } state_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [ACC_W-1:0] cordic_atan(input logic [STEP_W-1:0] i);
    logic [ACC_W-1:0] a;
    case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* hdl/swerve_wheel_speed_angle_top.sv */
// Top level of the swerve wheel speed and angle block with its register port.
// Each command yields one result per wheel in wheel order, the final one marked with
// last_wheel. For a nonzero command each wheel passes through the lever arm, the
// shared-multiplier products and squares, the sum and the launch, then 25
// one-bit-pair square-root steps with the 18-step CORDIC angle running alongside
// them, a completion flag and the result transfer. An all-zero command skips the
// computation and repeats each wheel's stored angle. A stalled result holds the
// block in its send state. The block takes a new command only once the last result
// of the previous one has been taken.
module swerve_wheel_speed_angle_top #(
  parameter int NUM_WHEELS = swv_pkg::NUM_WHEELS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  swv_pkg::cmd_t                 cmd,
  output logic                          res_valid,
  input  logic                          res_ready,
  output swv_pkg::res_t                 res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swv_pkg::ADDR_W-1:0]    paddr,
  input  logic [swv_pkg::DATA_W-1:0]    pwdata,
  output logic [swv_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import swv_pkg::*;

  localparam int WHEEL_COUNT = (NUM_WHEELS < 1) ? 1 :
                               ((NUM_WHEELS > MAX_WHEELS) ? MAX_WHEELS : NUM_WHEELS);

  state_t state, state_next;

  logic [DATA_W-1:0] rot_center;
  logic [DATA_W-1:0] wheel0_pos;
  logic [DATA_W-1:0] wheel1_pos;
  logic [DATA_W-1:0] wheel2_pos;
  logic [DATA_W-1:0] wheel3_pos;
  logic [REG_IDX_W-1:0] reg_idx;

  cmd_t                      cmd_q;
  logic                      cmd_zero;
  logic [WIDX_W-1:0]         wheel;
  logic                      wheel_last;
  logic [ANGLE_W-1:0]        last_angles [MAX_WHEELS];

  logic [DATA_W-1:0]         pos_sel;
  logic signed [POS_W-1:0]   px, py, cxs, cys;
  logic signed [ARM_W-1:0]   rx, ry;
  logic signed [WV_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [TERM_W-1:0]  tx, ty;
  logic signed [WV_W-1:0]    wx, wy;
  logic [SQ_W-1:0]           sq_x;
  logic [SQ_W-1:0]           sq_sum;

  logic                      vec_start;
  logic                      vec_done;
  logic [SPEED_W-1:0]        vec_speed;
  logic [ANGLE_W-1:0]        vec_angle;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_center <= '0;
      wheel0_pos <= '0;
      wheel1_pos <= '0;
      wheel2_pos <= '0;
      wheel3_pos <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ROT_CENTER: rot_center <= pwdata;
        REG_WHEEL0:     wheel0_pos <= pwdata;
        REG_WHEEL1:     wheel1_pos <= pwdata;
        REG_WHEEL2:     wheel2_pos <= pwdata;
        REG_WHEEL3:     wheel3_pos <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROT_CENTER: prdata = rot_center;
      REG_WHEEL0:     prdata = wheel0_pos;
      REG_WHEEL1:     prdata = wheel1_pos;
      REG_WHEEL2:     prdata = wheel2_pos;
      REG_WHEEL3:     prdata = wheel3_pos;
      default:        prdata = '0;
    endcase
  end

  // lever arm of the current wheel
  always_comb begin
    case (wheel)
      2'd0:    pos_sel = wheel0_pos;
      2'd1:    pos_sel = wheel1_pos;
      2'd2:    pos_sel = wheel2_pos;
      default: pos_sel = wheel3_pos;
    endcase
  end

  assign px  = pos_sel[POS_W-1:0];
  assign py  = pos_sel[DATA_W-1:POS_W];
  assign cxs = rot_center[POS_W-1:0];
  assign cys = rot_center[DATA_W-1:POS_W];
  assign wheel_last = (wheel == WIDX_W'(WHEEL_COUNT - 1));

  // shared multiplier
  always_comb begin
    case (state)
      ST_MUL_RY: begin
        mul_a = WV_W'(cmd_q.yaw_rate);
        mul_b = WV_W'(ry);
      end
      ST_MUL_RX: begin
        mul_a = WV_W'(cmd_q.yaw_rate);
        mul_b = WV_W'(rx);
      end
      ST_SQ_X: begin
        mul_a = wx;
        mul_b = wx;
      end
      ST_SQ_Y: begin
        mul_a = wy;
        mul_b = wy;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Q.24 velocity sums, rounded half up to Q.16 by the shift
  assign tx = {{(TERM_W - VEL_W - 16){cmd_q.vel_x[VEL_W-1]}}, cmd_q.vel_x, 16'h0000}
            + TERM_W'(prod_q) + TERM_W'(ROUND_HALF);
  assign ty = {{(TERM_W - VEL_W - 16){cmd_q.vel_y[VEL_W-1]}}, cmd_q.vel_y, 16'h0000}
            - TERM_W'(prod_q) + TERM_W'(ROUND_HALF);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    vec_start  = 1'b0;
    cmd_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          state_next = ((cmd.vel_x == '0) && (cmd.vel_y == '0) && (cmd.yaw_rate == '0))
                     ? ST_ZERO : ST_DIFF;
        end
      end
      ST_DIFF:   state_next = ST_MUL_RY;
      ST_MUL_RY: state_next = ST_MUL_RX;
      ST_MUL_RX: state_next = ST_SQ_X;
      ST_SQ_X:   state_next = ST_SQ_Y;
      ST_SQ_Y:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_VEC_GO;
      ST_VEC_GO: begin
        vec_start  = 1'b1;
        state_next = ST_VEC_WAIT;
      end
      ST_VEC_WAIT: if (vec_done) state_next = ST_SEND;
      ST_ZERO:     state_next = ST_SEND;
      ST_SEND: begin
        if (res_ready) begin
          if (wheel_last)    state_next = ST_IDLE;
          else if (cmd_zero) state_next = ST_ZERO;
          else               state_next = ST_DIFF;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      wheel     <= '0;
      for (int i = 0; i < MAX_WHEELS; i++) last_angles[i] <= '0;
    end else begin
      case (state)
        ST_IDLE: if (cmd_valid) wheel <= '0;
        ST_VEC_WAIT: begin
          if (vec_done) begin
            res_valid          <= 1'b1;
            last_angles[wheel] <= vec_angle;
          end
        end
        ST_ZERO: res_valid <= 1'b1;
        ST_SEND: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            wheel     <= wheel + WIDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_q <= prod;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_q    <= cmd;
          cmd_zero <= (cmd.vel_x == '0) && (cmd.vel_y == '0) && (cmd.yaw_rate == '0);
        end
      end
      ST_DIFF: begin
        rx <= ARM_W'(px) - ARM_W'(cxs);
        ry <= ARM_W'(py) - ARM_W'(cys);
      end
      ST_MUL_RX: wx   <= tx[TERM_W-1:FRAC_DROP];
      ST_SQ_X:   wy   <= ty[TERM_W-1:FRAC_DROP];
      ST_SQ_Y:   sq_x <= prod_q[SQ_W-1:0];
      ST_SUM:    sq_sum <= sq_x + prod_q[SQ_W-1:0];
      ST_VEC_WAIT: begin
        if (vec_done) begin
          res.wheel_index <= wheel;
          res.wheel_speed <= vec_speed;
          res.wheel_angle <= vec_angle;
          res.last_wheel  <= wheel_last;
        end
      end
      ST_ZERO: begin
        res.wheel_index <= wheel;
        res.wheel_speed <= '0;
        res.wheel_angle <= last_angles[wheel];
        res.last_wheel  <= wheel_last;
      end
      default: ;
    endcase
  end

  swv_vec u_vec (
    .clk   (clk),
    .rst   (rst),
    .start (vec_start),
    .n     (sq_sum),
    .x     (wx),
    .y     (wy),
    .done  (vec_done),
    .speed (vec_speed),
    .angle (vec_angle)
  );

endmodule

/* hdl/swv_vec.sv */
// Iterative magnitude (bit-pair square root) and CORDIC angle of one wheel vector.
module swv_vec (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [swv_pkg::SQ_W-1:0]           n,
  input  logic signed [swv_pkg::WV_W-1:0]    x,
  input  logic signed [swv_pkg::WV_W-1:0]    y,
  output logic                               done,
  output logic [swv_pkg::SPEED_W-1:0]        speed,
  output logic [swv_pkg::ANGLE_W-1:0]        angle
);
  import swv_pkg::*;

  logic                       busy;
  logic [STEP_W-1:0]          cnt;
  logic [SQ_W-1:0]            rem;
  logic [SQ_W-1:0]            root;
  logic [SQ_W-1:0]            bitm;
  logic signed [CORDIC_W-1:0] cx;
  logic signed [CORDIC_W-1:0] cy;
  logic [ACC_W-1:0]           acc;
  logic                       vec_zero;

  logic [SQ_W:0]              trial;
  logic                       take;
  logic signed [CORDIC_W-1:0] xe;
  logic signed [CORDIC_W-1:0] ye;
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic [WV_W:0]              spd_round;
  logic [ACC_W-1:0]           ang_round;

  assign trial = {1'b0, root} + {1'b0, bitm};
  assign take  = ({1'b0, rem} >= trial);
  assign xe    = CORDIC_W'(x);
  assign ye    = CORDIC_W'(y);
  assign xs    = cx >>> cnt;
  assign ys    = cy >>> cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(ROOT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= n;
      root     <= '0;
      bitm     <= SQ_W'(1) << (SQ_W - 2);
      vec_zero <= (x == '0) && (y == '0);
      // pre-rotate into the right half plane
      if (xe < 0) begin
        if (ye >= 0) begin
          cx  <= ye;
          cy  <= -xe;
          acc <= 32'h4000_0000;
        end else begin
          cx  <= -ye;
          cy  <= xe;
          acc <= 32'hC000_0000;
        end
      end else begin
        cx  <= xe;
        cy  <= ye;
        acc <= '0;
      end
    end else if (busy) begin
      if (take) begin
        rem  <= rem - trial[SQ_W-1:0];
        root <= (root >> 1) + bitm;
      end else begin
        root <= root >> 1;
      end
      bitm <= bitm >> 2;
      if (cnt < STEP_W'(CORDIC_STEPS)) begin
        if (cy > 0) begin
          cx  <= cx + ys;
          cy  <= cy - xs;
          acc <= acc + cordic_atan(cnt);
        end else begin
          cx  <= cx - ys;
          cy  <= cy + xs;
          acc <= acc - cordic_atan(cnt);
        end
      end
    end
  end

  // round to Q.8 and saturate
  assign spd_round = {1'b0, root[WV_W-1:0]} + (WV_W + 1)'(ROUND_HALF);
  assign speed     = (spd_round[WV_W:FRAC_DROP + SPEED_W] != '0) ? '1
                   : spd_round[FRAC_DROP + SPEED_W - 1:FRAC_DROP];
  assign ang_round = acc + 32'h0000_8000;
  assign angle     = vec_zero ? '0 : ang_round[ACC_W-1:ACC_W-ANGLE_W];

endmodule

/* hdl/swv_checker.sv */
// Port-level checks of the swerve wheel block, bound to its top level.
`include "swerve_wheel_speed_angle_top_macros.svh"

module swv_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input logic          res_valid,
  input logic          res_ready,
  input swv_pkg::res_t res
);
  import swv_pkg::*;

  // a stalled result holds
  `SWV_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")
  // no command is taken while a result is pending
  `SWV_ASSERT_NOW(a_excl, clk, rst, res_valid, !cmd_ready, "command ready while result pending")
  // one command at a time
  `SWV_ASSERT_NEXT(a_cmd_busy, clk, rst, cmd_valid && cmd_ready, !cmd_ready && !res_valid, "block not busy after command transfer")
  // the final result returns the block to accepting commands
  `SWV_ASSERT_NEXT(a_last_done, clk, rst, res_valid && res_ready && res.last_wheel, cmd_ready && !res_valid, "block not ready after final result")
  // the next wheel result is computed, never reissued at once
  `SWV_ASSERT_NEXT(a_no_repeat, clk, rst, res_valid && res_ready, !res_valid, "result valid right after transfer")

endmodule

bind swerve_wheel_speed_angle_top swv_checker u_swv_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
